FILE: rtl/rtt_pkg.sv
package rtt_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int SLOT_W          = 3;
    localparam int ATT_W           = 8;
    localparam int WAIT_W          = 16;

    localparam logic [WAIT_W-1:0] RESEND_RESET = 16'd10;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ARM  = 1'b1;

    localparam logic KIND_RESEND  = 1'b0;
    localparam logic KIND_GAVE_UP = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] slot;
        logic [ATT_W-1:0]  attempts;
        logic [WAIT_W-1:0] first_wait;
    } req_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] event_slot;
        logic              event_kind;
        logic              last;
    } evt_item_t;

endpackage

FILE: rtl/retransmit_timer_table_top.sv
// Arm request: accepted while idle, next request taken the cycle after.
// Tick request: one sequencer walks the slot table through a single shared
//   decrement/compare unit: a free slot gets a read step only, a busy slot a
//   memory read, then evaluate and write back; the walk opens with an accept
//   step and closes with a flush step, and waits while events back up.
// Reset (rst_n low, async): all slots free, no event pending, interval 10.
module retransmit_timer_table_top
    import rtt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_item_t         req_data,
    output logic              evt_valid,
    input  logic              evt_ready,
    output evt_item_t         evt_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WAIT_W-1:0] cfg_data
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [WAIT_W-1:0]      resend_reg;
    logic [QUEUE_DEPTH-1:0] busy_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;

    // slot table; countdown and attempts share one write and one read port
    logic [WAIT_W-1:0] wait_mem_reg [QUEUE_DEPTH];
    logic [ATT_W-1:0]  att_mem_reg  [QUEUE_DEPTH];
    logic [WAIT_W-1:0] rd_wait_reg;
    logic [ATT_W-1:0]  rd_att_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WAIT_W-1:0] wr_wait;
    logic [ATT_W-1:0]  wr_att;

    // one event held back until we know whether another follows (last flag)
    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic              pend_kind_reg, pend_kind_next;

    logic      evt_valid_reg;
    evt_item_t evt_data_reg;
    logic      push;
    evt_item_t push_data;
    logic      can_push;

    logic arm_ok;
    logic expire;
    logic give_up;
    logic stall;
    logic free_slot;
    logic busy_set;
    logic busy_clr;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign evt_valid = evt_valid_reg;
    assign evt_data  = evt_data_reg;

    assign can_push = !evt_valid_reg || evt_ready;
    assign arm_ok   = (32'(req_data.slot) < QUEUE_DEPTH);

    // shared compare unit on the registered read data
    assign expire  = (rd_wait_reg <= WAIT_W'(1));
    assign give_up = (rd_att_reg <= ATT_W'(1));
    assign stall   = expire && pend_valid_reg && !can_push;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_kind_next  = pend_kind_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_wait         = rd_wait_reg;
        wr_att          = rd_att_reg;
        push            = 1'b0;
        push_data       = '{event_slot: pend_slot_reg, event_kind: pend_kind_reg, last: 1'b0};
        busy_set        = 1'b0;
        busy_clr        = 1'b0;
        free_slot       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_data.func == FUNC_ARM)
                    begin
                        if (arm_ok)
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = IDX_W'(req_data.slot);
                            wr_wait  = req_data.first_wait;
                            wr_att   = req_data.attempts;
                            busy_set = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                if (busy_reg[idx_reg])
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    free_slot = 1'b1;
                end
            end

            S_EVAL:
            begin
                if (!stall)
                begin
                    wr_en     = 1'b1;
                    free_slot = 1'b1;
                    if (!expire)
                    begin
                        wr_wait = rd_wait_reg - WAIT_W'(1);
                    end
                    else
                    begin
                        if (give_up)
                        begin
                            wr_wait  = '0;
                            wr_att   = '0;
                            busy_clr = 1'b1;
                        end
                        else
                        begin
                            wr_wait = resend_reg;
                            wr_att  = rd_att_reg - ATT_W'(1);
                        end
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_slot_next  = SLOT_W'(idx_reg);
                        pend_kind_next  = give_up ? KIND_GAVE_UP : KIND_RESEND;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    push            = 1'b1;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next slot, or close the walk
        if (free_slot)
        begin
            if (idx_reg == IDX_LAST)
            begin
                state_next = S_FLUSH;
            end
            else
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            busy_reg       <= '0;
            resend_reg     <= RESEND_RESET;
            pend_valid_reg <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                resend_reg <= cfg_data;
            end
            if (busy_set)
            begin
                busy_reg[wr_addr] <= 1'b1;
            end
            else if (busy_clr)
            begin
                busy_reg[idx_reg] <= 1'b0;
            end
            if (push)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_kind_reg <= pend_kind_next;
        if (push)
        begin
            evt_data_reg <= push_data;
        end
    end

    // slot table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wait_mem_reg[wr_addr] <= wr_wait;
            att_mem_reg[wr_addr]  <= wr_att;
        end
        rd_wait_reg <= wait_mem_reg[idx_reg];
        rd_att_reg  <= att_mem_reg[idx_reg];
    end

    // no held-back event survives the end of a walk
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("event still held back while idle");

    // a new event never overwrites one the consumer has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!evt_valid_reg || evt_ready))
        else $error("event register overwritten");

    // only busy slots are evaluated
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> busy_reg[idx_reg])
        else $error("free slot evaluated");

endmodule

FILE: bench/retransmit_timer_table_top_tb.sv
module retransmit_timer_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtt_pkg::*;

    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int CLK_PERIOD     = 8;
    localparam int SETTLE_CYCLES  = 40;    // long enough for the worst tick walk
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
    localparam int PHASE_ITEMS    = 56;
    localparam int NUM_PHASES     = 5;
    localparam int MAX_REPORTS    = 60;

    // Per-request bookkeeping: a hand-typed expectation for directed rows,
    // otherwise the predictor decides.
    typedef struct packed {
        logic      typed;
        logic      has_evt;
        evt_item_t ev;
    } hand_check_t;

    typedef struct packed {
        req_item_t   item;
        hand_check_t chk;
    } dir_row_t;

    // Receiver stall patterns.
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    localparam hand_check_t NO_CHECK = '0;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_item_t         req_data  = '0;
    logic              evt_valid;
    logic              evt_ready = 1'b0;
    evt_item_t         evt_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WAIT_W-1:0] cfg_data  = '0;

    // Predictor state: our own copy of the slot table and the interval.
    logic              t_busy  [DEPTH];
    logic [WAIT_W-1:0] t_wait  [DEPTH];
    logic [ATT_W-1:0]  t_tries [DEPTH];
    logic [WAIT_W-1:0] t_interval;

    // Events produced by the latest predicted tick.
    evt_item_t fresh [DEPTH];
    int        fresh_n;

    evt_item_t   due_events  [$];   // expected events, oldest first
    hand_check_t hand_checks [$];   // one entry per request offered, in order

    int  fail_count  = 0;
    int  n_arms      = 0;
    int  n_ticks     = 0;
    int  n_resend    = 0;
    int  n_gaveup    = 0;
    int  n_settings  = 0;
    int  idle_cycles = 0;
    int  hold_req    = 0;    // bumped by the stimulus to ask for a hold-off
    int  hold_done   = 0;    // caught up by the receiver once it is over
    bit  hold_active = 1'b0;
    bit  req_up      = 1'b0; // request valid currently raised by us

    retransmit_timer_table_top #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt_data  (evt_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_table();
        for (int i = 0; i < DEPTH; i++)
        begin
            t_busy[i]  = 1'b0;
            t_wait[i]  = '0;
            t_tries[i] = '0;
        end
        t_interval = RESEND_RESET;
    endfunction

    // Arm: overwrite the slot, busy or not. Slots past the table are dropped.
    function automatic void arm_slot(req_item_t r);
        if (int'(r.slot) < DEPTH)
        begin
            t_busy[r.slot]  = 1'b1;
            t_tries[r.slot] = r.attempts;
            t_wait[r.slot]  = r.first_wait;
        end
    endfunction

    // Tick: walk busy slots in ascending order. A countdown of zero or one
    // expires; zero attempts behave like one.
    function automatic void tick_table();
        fresh_n = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (t_busy[i])
            begin
                if (t_wait[i] > 16'd1)
                    t_wait[i] = t_wait[i] - 1'b1;
                else
                begin
                    fresh[fresh_n].event_slot = SLOT_W'(i);
                    fresh[fresh_n].last       = 1'b0;
                    if (t_tries[i] <= 8'd1)
                    begin
                        t_tries[i] = '0;
                        t_wait[i]  = '0;
                        t_busy[i]  = 1'b0;
                        fresh[fresh_n].event_kind = KIND_GAVE_UP;
                    end
                    else
                    begin
                        t_tries[i] = t_tries[i] - 1'b1;
                        t_wait[i]  = t_interval;
                        fresh[fresh_n].event_kind = KIND_RESEND;
                    end
                    fresh_n++;
                end
            end
        end
        if (fresh_n > 0)
            fresh[fresh_n - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Port monitor: everything is sampled at the rising edge, before the
    // block's own updates land, so it sees exactly what the flops see.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : port_watch
        hand_check_t hc;
        evt_item_t   want;
        if (rst_n)
        begin
            // Events first: they can only stem from requests accepted earlier.
            if (evt_valid && evt_ready)
            begin
                if (evt_data.event_kind == KIND_GAVE_UP)
                    n_gaveup++;
                else
                    n_resend++;
                if (due_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("unexpected event: slot %0d kind %0d last %0d",
                               evt_data.event_slot, evt_data.event_kind, evt_data.last);
                end
                else
                begin
                    want = due_events.pop_front();
                    check_field("event_slot", want.event_slot, evt_data.event_slot);
                    check_field("event_kind", want.event_kind, evt_data.event_kind);
                    check_field("last", want.last, evt_data.last);
                end
            end

            if (req_valid && req_ready)
            begin
                hc = (hand_checks.size() != 0) ? hand_checks.pop_front() : NO_CHECK;
                fresh_n = 0;
                if (req_data.func == FUNC_ARM)
                begin
                    arm_slot(req_data);
                    n_arms++;
                end
                else
                begin
                    tick_table();
                    n_ticks++;
                end
                // Hand-typed rows override the predictor, which still advances.
                if (hc.typed)
                begin
                    if (hc.has_evt)
                        due_events.push_back(hc.ev);
                end
                else
                begin
                    for (int k = 0; k < fresh_n; k++)
                        due_events.push_back(fresh[k]);
                end
            end

            if (cfg_valid && cfg_ready)
                t_interval = cfg_data;
        end
    end

    // Watchdog: a run that stops moving on every channel is a failure.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (evt_valid && evt_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles, %0d events outstanding",
                     idle_cycles, due_events.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Event receiver: random stretches of different stall patterns, plus a
    // long hold-off on request from the stimulus, counted here.
    // ------------------------------------------------------------------
    initial
    begin : evt_pacer
        rx_mode_t mode;
        int       stretch;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_done != hold_req)
            begin
                evt_ready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_done = hold_req;
            end
            else
            begin
                mode    = rx_mode_t'($urandom_range(0, 3));
                stretch = $urandom_range(1, 40);
                for (int k = 0; k < stretch && hold_done == hold_req; k++)
                begin
                    case (mode)
                        RX_OPEN:   evt_ready <= 1'b1;
                        RX_COIN:   evt_ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: evt_ready <= ($urandom_range(0, 3) == 0);
                        default:   evt_ready <= k[0];
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request sender helpers
    // ------------------------------------------------------------------

    // Offer one request and hold it until accepted. Valid is left high so a
    // following request goes out back to back.
    task automatic send_req(req_item_t it, hand_check_t hc);
        hand_checks.push_back(hc);
        req_data  <= it;
        req_valid <= 1'b1;
        req_up = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic release_req();
        if (req_up)
        begin
            req_valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    // Stop sending, wait for every expected event, then let a possibly
    // event-less tick walk finish.
    task automatic drain();
        release_req();
        @(posedge clk);
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_interval(logic [WAIT_W-1:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mostly small attempt counts and waits so slots keep expiring; now and
    // then full-width values. Tick requests carry random junk in the fields
    // that a tick ignores.
    function automatic req_item_t random_request();
        req_item_t r;
        r.func = ($urandom_range(0, 99) < 35) ? FUNC_ARM : FUNC_TICK;
        if (r.func == FUNC_ARM)
        begin
            r.slot       = SLOT_W'($urandom_range(0, DEPTH - 1));
            r.attempts   = ($urandom_range(0, 4) == 0) ? ATT_W'($urandom)
                                                       : ATT_W'($urandom_range(0, 4));
            r.first_wait = ($urandom_range(0, 4) == 0) ? WAIT_W'($urandom)
                                                       : WAIT_W'($urandom_range(0, 6));
        end
        else
        begin
            r.slot       = SLOT_W'($urandom);
            r.attempts   = ATT_W'($urandom);
            r.first_wait = WAIT_W'($urandom);
        end
        return r;
    endfunction

    // Bursts of random length; most bursts are followed by a random gap.
    task automatic run_random(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send_req(random_request(), NO_CHECK);
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                release_req();
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // Fill all slots so each tick expires all of them, then hold the
    // receiver off while ticks keep coming: the block has to stall requests.
    task automatic flood_events();
        req_item_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            r = '{func: FUNC_ARM, slot: SLOT_W'(i), attempts: 8'd255, first_wait: 16'd0};
            send_req(r, NO_CHECK);
        end
        // drop valid while waiting for the hold-off so the last arm is not offered again
        release_req();
        hold_req++;
        while (!hold_active)
            @(posedge clk);
        r = '0;
        r.func = FUNC_TICK;
        for (int i = 0; i < DEPTH; i++)
            send_req(r, NO_CHECK);
        drain();
    endtask

    // Directed table row builders.
    function automatic dir_row_t arm_row(int s, int a, int w);
        dir_row_t r;
        r.item = '{func: FUNC_ARM, slot: SLOT_W'(s), attempts: ATT_W'(a),
                   first_wait: WAIT_W'(w)};
        r.chk  = '{typed: 1'b1, has_evt: 1'b0, ev: '0};
        return r;
    endfunction

    // hand = expectation typed in here; has = one event (slot s, kind) that
    // is also the last one. junk fills the ignored fields with ones.
    function automatic dir_row_t tick_row(logic hand, logic has, int s, logic kind,
                                          logic junk);
        dir_row_t r;
        r.item      = '0;
        r.item.func = FUNC_TICK;
        if (junk)
        begin
            r.item.slot       = '1;
            r.item.attempts   = '1;
            r.item.first_wait = '1;
        end
        r.chk.typed   = hand;
        r.chk.has_evt = has;
        r.chk.ev      = '{event_slot: SLOT_W'(s), event_kind: kind, last: 1'b1};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t          directed [$];
        logic [WAIT_W-1:0] settings [NUM_PHASES];

        clear_table();

        // Reset once, released on a rising edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, resend interval at its reset value of 10.
        // Nothing armed yet: a tick right after reset yields no event.
        directed.push_back(tick_row(1'b1, 1'b0, 0, KIND_RESEND, 1'b0));
        // Single attempt: the first expiry gives up.
        directed.push_back(arm_row(0, 1, 1));
        directed.push_back(tick_row(1'b1, 1'b1, 0, KIND_GAVE_UP, 1'b1));
        // Zero attempts and zero wait: expires at once and gives up.
        directed.push_back(arm_row(7, 0, 0));
        directed.push_back(tick_row(1'b1, 1'b1, 7, KIND_GAVE_UP, 1'b0));
        // Largest attempts and wait stay quiet; slot 5 resends once.
        directed.push_back(arm_row(3, 255, 65535));
        directed.push_back(arm_row(5, 2, 1));
        directed.push_back(tick_row(1'b1, 1'b1, 5, KIND_RESEND, 1'b1));
        // Re-arm of a busy slot overwrites it.
        directed.push_back(arm_row(5, 1, 2));
        directed.push_back(tick_row(1'b1, 1'b0, 0, KIND_RESEND, 1'b0));
        directed.push_back(tick_row(1'b1, 1'b1, 5, KIND_GAVE_UP, 1'b0));
        // Every slot armed: one tick expires all eight.
        for (int i = 0; i < DEPTH; i++)
            directed.push_back(arm_row(i, 3, i % 2));
        directed.push_back(tick_row(1'b0, 1'b0, 0, KIND_RESEND, 1'b0));
        directed.push_back(tick_row(1'b0, 1'b0, 0, KIND_RESEND, 1'b1));
        directed.push_back(arm_row(2, 255, 65535));
        directed.push_back(tick_row(1'b0, 1'b0, 0, KIND_RESEND, 1'b0));

        foreach (directed[i])
            send_req(directed[i].item, directed[i].chk);

        // Random phases over several intervals: smallest nonzero, zero (expires on
        // the next tick like one), largest, a short one and a full-width one.
        settings[0] = 16'd1;
        settings[1] = 16'd0;
        settings[2] = 16'hFFFF;
        settings[3] = WAIT_W'($urandom_range(2, 12));
        settings[4] = WAIT_W'($urandom);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_interval(settings[p]);
            if (p == 0)
                flood_events();
            run_random(PHASE_ITEMS);
        end

        // Let the last tick walks and events play out.
        drain();

        $display("Covered %0d requests (%0d arms, %0d ticks) under %0d interval settings,",
                 n_arms + n_ticks, n_arms, n_ticks, n_settings + 1);
        $display("with %0d resend and %0d give-up events and one long receiver hold-off.",
                 n_resend, n_gaveup);
        if (fail_count == 0 && due_events.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
